// ===== sv/bam_pkg.sv =====
// Shared constants and types for the block average mosaic.
package bam_pkg;
  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 2048;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CoordW = 11;
  localparam int unsigned CntW   = 23;
  localparam int unsigned SumW   = 30;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegDivX = 2'd2;
  localparam logic [1:0] RegDivY = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [SumW-1:0]   sum_r;
    logic [SumW-1:0]   sum_g;
    logic [SumW-1:0]   sum_b;
    logic [CntW-1:0]   count;
    logic              last;
  } bam_job_t;
endpackage

// ===== sv/bam_div.sv =====
// Sequential divider: three channel sums by one pixel count, one quotient bit per cycle.
module bam_div import bam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  bam_job_t job,
  output logic     job_ready,
  output logic     res_valid,
  output logic [CoordW-1:0] res_col,
  output logic [CoordW-1:0] res_row,
  output logic [7:0] res_r,
  output logic [7:0] res_g,
  output logic [7:0] res_b,
  output logic     res_last,
  input  logic     res_ready
);
  typedef enum logic [1:0] {IDLE, RUN, DONE} st_t;
  st_t st_r;
  logic [4:0] bit_r;
  bam_job_t j_r;
  logic [SumW-1:0] rem_r [3];
  logic [SumW-1:0] quo_r [3];
  logic [SumW:0] shifted [3];
  logic [SumW:0] diff [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      shifted[c] = {rem_r[c], (c == 0) ? j_r.sum_r[bit_r] :
                              (c == 1) ? j_r.sum_g[bit_r] : j_r.sum_b[bit_r]};
      diff[c] = shifted[c] - {{(SumW+1-CntW){1'b0}}, j_r.count};
    end
  end

  assign job_ready = (st_r == IDLE);
  assign res_valid = (st_r == DONE);
  assign res_col = j_r.col;
  assign res_row = j_r.row;
  assign res_r = quo_r[0][7:0];
  assign res_g = quo_r[1][7:0];
  assign res_b = quo_r[2][7:0];
  assign res_last = j_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= IDLE;
    end else begin
      case (st_r)
        IDLE: if (job_valid) begin
          j_r <= job;
          bit_r <= 5'(SumW-1);
          for (int c = 0; c < 3; c++) begin
            rem_r[c] <= '0;
            quo_r[c] <= '0;
          end
          st_r <= RUN;
        end
        RUN: begin
          for (int c = 0; c < 3; c++) begin
            if (!diff[c][SumW]) begin
              rem_r[c] <= diff[c][SumW-1:0];
              quo_r[c] <= {quo_r[c][SumW-2:0], 1'b1};
            end else begin
              rem_r[c] <= shifted[c][SumW-1:0];
              quo_r[c] <= {quo_r[c][SumW-2:0], 1'b0};
            end
          end
          if (bit_r == '0) st_r <= DONE;
          else bit_r <= bit_r - 5'd1;
        end
        DONE: if (res_ready) st_r <= IDLE;
        default: st_r <= IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == RUN && bit_r == '0) |=> res_valid) else $error("divider did not finish");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == RUN) |-> (j_r.count != '0)) else $error("zero count");
endmodule

// ===== sv/bam_front.sv =====
// Raster tracking and per-block-column sum accumulation.
module bam_front import bam_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [CfgW-1:0] cfg_data,
  input  logic in_valid,
  input  logic [7:0] in_r,
  input  logic [7:0] in_g,
  input  logic [7:0] in_b,
  output logic in_ready,
  output logic job_valid,
  output bam_job_t job,
  input  logic job_ready
);
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1;
  localparam int unsigned SW = $clog2(YW);
  localparam int unsigned DW = CfgW + 1;
  typedef enum logic [2:0] {CLR, DIVX, DIVY, READY, RD, ACC, EMIT} st_t;

  st_t st_r;
  logic [CfgW-1:0] wreg_r, hreg_r, dxreg_r, dyreg_r;
  logic [YW-1:0] w_r, h_r;
  logic [YW-1:0] sx_r, sy_r;
  logic [DW-1:0] acc_r;
  logic [YW-1:0] quo_r;
  logic [XW:0] clr_r;
  logic [YW-1:0] x_r, y_r, ox_r, oy_r, by_r;
  logic [XW-1:0] bc_r;
  logic [SumW*3-1:0] mem [MAX_WIDTH];
  logic [SumW*3-1:0] rd_r;
  logic [7:0] pr_r, pg_r, pb_r;
  logic [SumW-1:0] nr, ng, nb;
  logic end_line, end_frame, end_x, end_y, bx_step, by_step;
  logic [CfgW-1:0] dcur;
  logic [DW-1:0] trial;
  logic [5:0] step_r;

  function automatic logic [YW-1:0] clampsz(logic [CfgW-1:0] v, int unsigned m);
    logic [YW-1:0] r;
    r = YW'(v);
    if (v == '0) r = YW'(1);
    else if (32'(v) > m) r = YW'(m);
    return r;
  endfunction

  assign nr = rd_r[3*SumW-1:2*SumW] + SumW'(pr_r);
  assign ng = rd_r[2*SumW-1:SumW] + SumW'(pg_r);
  assign nb = rd_r[SumW-1:0] + SumW'(pb_r);
  assign end_line = (x_r + 1'b1 >= w_r);
  assign end_y = (oy_r + 1'b1 >= sy_r) || (y_r + 1'b1 >= h_r);
  assign end_frame = end_line && (y_r + 1'b1 >= h_r);
  assign bx_step = (ox_r + 1'b1 >= sx_r);
  assign end_x = bx_step || end_line;
  assign by_step = (oy_r + 1'b1 >= sy_r);
  assign in_ready = (st_r == READY);
  assign dcur = (st_r == DIVX) ? ((dxreg_r == '0) ? CfgW'(1) : dxreg_r)
                               : ((dyreg_r == '0) ? CfgW'(1) : dyreg_r);
  // restoring division for the strides, one bit per cycle
  assign trial = {acc_r[DW-2:0],
                  ((st_r == DIVX) ? w_r[step_r[SW-1:0]] : h_r[step_r[SW-1:0]])};

  always_ff @(posedge clk) begin
    if (st_r == CLR) mem[clr_r[XW-1:0]] <= '0;
    else if (st_r == ACC) mem[bc_r] <= (end_x && end_y) ? '0 : {nr, ng, nb};
    rd_r <= mem[bc_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wreg_r <= CfgW'(640); hreg_r <= CfgW'(480);
      dxreg_r <= CfgW'(8); dyreg_r <= CfgW'(8);
      st_r <= CLR; clr_r <= '0; job_valid <= 1'b0;
      x_r <= '0; y_r <= '0; ox_r <= '0; oy_r <= '0; bc_r <= '0; by_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegWidth: wreg_r <= cfg_data;
        RegHeight: hreg_r <= cfg_data;
        RegDivX: dxreg_r <= cfg_data;
        RegDivY: dyreg_r <= cfg_data;
        default: ;
      endcase
      st_r <= CLR; clr_r <= '0; job_valid <= 1'b0;
      x_r <= '0; y_r <= '0; ox_r <= '0; oy_r <= '0; bc_r <= '0; by_r <= '0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      case (st_r)
        CLR: begin
          clr_r <= clr_r + 1'b1;
          w_r <= clampsz(wreg_r, MAX_WIDTH);
          h_r <= clampsz(hreg_r, MAX_HEIGHT);
          if (clr_r == (XW+1)'(MAX_WIDTH-1)) begin
            st_r <= DIVX; acc_r <= '0; step_r <= 6'(YW-1); quo_r <= '0;
          end
        end
        DIVX, DIVY: begin
          if (trial >= DW'(dcur)) begin
            acc_r <= trial - DW'(dcur); quo_r <= {quo_r[YW-2:0], 1'b1};
          end else begin
            acc_r <= trial; quo_r <= {quo_r[YW-2:0], 1'b0};
          end
          if (step_r == '0) begin
            if (st_r == DIVX) begin
              sx_r <= ({quo_r[YW-2:0], trial >= DW'(dcur)} == '0) ? YW'(1)
                      : {quo_r[YW-2:0], trial >= DW'(dcur)};
              st_r <= DIVY; acc_r <= '0; step_r <= 6'(YW-1); quo_r <= '0;
            end else begin
              sy_r <= ({quo_r[YW-2:0], trial >= DW'(dcur)} == '0) ? YW'(1)
                      : {quo_r[YW-2:0], trial >= DW'(dcur)};
              st_r <= READY;
            end
          end else begin
            step_r <= step_r - 6'd1;
          end
        end
        READY: if (in_valid) begin
          pr_r <= in_r; pg_r <= in_g; pb_r <= in_b; st_r <= RD;
        end
        // a finishing block waits here while the job slot is still taken
        RD: if (!(end_x && end_y && job_valid && !job_ready)) st_r <= ACC;
        ACC: begin
          if (end_x && end_y) begin
            job.col <= CoordW'(bc_r);
            job.row <= CoordW'(by_r);
            job.sum_r <= nr; job.sum_g <= ng; job.sum_b <= nb;
            job.count <= CntW'(ox_r + 1'b1) * CntW'(oy_r + 1'b1);
            job.last <= end_frame;
          end
          st_r <= (end_x && end_y) ? EMIT : READY;
          if (end_line) begin
            x_r <= '0; ox_r <= '0; bc_r <= '0;
            if (end_frame) begin
              y_r <= '0; oy_r <= '0; by_r <= '0;
            end else begin
              y_r <= y_r + 1'b1;
              oy_r <= by_step ? '0 : oy_r + 1'b1;
              if (by_step) by_r <= by_r + 1'b1;
            end
          end else begin
            x_r <= x_r + 1'b1;
            if (bx_step) begin
              ox_r <= '0; bc_r <= bc_r + 1'b1;
            end else begin
              ox_r <= ox_r + 1'b1;
            end
          end
        end
        EMIT: if (!job_valid) begin
          job_valid <= 1'b1; st_r <= READY;
        end
        default: st_r <= READY;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
    (st_r == READY) |-> (sx_r != '0 && sy_r != '0)) else $error("zero stride");
  assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
    (st_r == READY) |-> (x_r < w_r && y_r < h_r)) else $error("position out of frame");
  assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
    (st_r == READY) |-> (ox_r < sx_r)) else $error("block offset overflow");
endmodule

// ===== sv/block_average_mosaic.sv =====
// Block average mosaic: raster RGB in, one mean per finished block out.
// Pixels arrive in raster order through a queue-style port (push/full). The
// frame is split into blocks of (width/divisions_x) x (height/divisions_y);
// running sums per block column live in a MAX_WIDTH-deep memory. When a
// block's bottom-right pixel arrives the front end hands its sums and pixel
// count to a bit-serial divider, whose result waits on the out_ ports until
// popped. A pixel passes the front end in steps (accept, memory read, add
// and write back); a pixel that finishes a block also hands the job over.
// The divider holds each result word until it is popped and returns to idle
// before it can load the next job. The front end keeps accepting pixels
// meanwhile and stalls only when a block finishes while the job of the
// block before is still waiting for the divider to take it. After reset and
// after any write to a known configuration register, the sum memory is
// cleared and the strides are computed; full is high during that time.
// Such configuration writes restart the frame.
module block_average_mosaic import bam_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic push,
  output logic full,
  input  logic [7:0] in_pixel_red,
  input  logic [7:0] in_pixel_green,
  input  logic [7:0] in_pixel_blue,
  output logic empty,
  input  logic pop,
  output logic [CoordW-1:0] out_block_column,
  output logic [CoordW-1:0] out_block_row,
  output logic [7:0] out_mean_red,
  output logic [7:0] out_mean_green,
  output logic [7:0] out_mean_blue,
  output logic out_frame_done
);
  logic in_ready, job_valid, job_ready, res_valid, we_known;
  bam_job_t job;

  // indexes beyond the register list are ignored entirely
  assign we_known = cfg_we && (cfg_index[2] == 1'b0);

  bam_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .cfg_we(we_known), .cfg_idx(cfg_index[1:0]), .cfg_data,
    .in_valid(push), .in_r(in_pixel_red), .in_g(in_pixel_green),
    .in_b(in_pixel_blue), .in_ready, .job_valid, .job, .job_ready
  );

  bam_div u_div (
    .clk, .rst_n, .job_valid, .job, .job_ready, .res_valid,
    .res_col(out_block_column), .res_row(out_block_row),
    .res_r(out_mean_red), .res_g(out_mean_green), .res_b(out_mean_blue),
    .res_last(out_frame_done), .res_ready(pop)
  );

  assign full = !in_ready;
  assign empty = !res_valid;
endmodule

// ===== tb/sv/block_average_mosaic_check.sv =====
// Checker for the block average mosaic: predicts block means and compares popped words.
module block_average_mosaic_check import bam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  input  logic              push,
  input  logic              full,
  input  logic [7:0]        in_pixel_red,
  input  logic [7:0]        in_pixel_green,
  input  logic [7:0]        in_pixel_blue,
  input  logic              empty,
  input  logic              pop,
  input  logic [CoordW-1:0] out_block_column,
  input  logic [CoordW-1:0] out_block_row,
  input  logic [7:0]        out_mean_red,
  input  logic [7:0]        out_mean_green,
  input  logic [7:0]        out_mean_blue,
  input  logic              out_frame_done,
  output int                mismatches,
  output int                blocks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LineMax  = DefMaxWidth;
  localparam int unsigned FrameMax = DefMaxHeight;

  typedef struct {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic              done;
  } block_mean_t;

  block_mean_t block_q[$];

  logic [CfgW-1:0] width_reg, height_reg, divx_reg, divy_reg;
  int unsigned sum_r[LineMax];
  int unsigned sum_g[LineMax];
  int unsigned sum_b[LineMax];
  int unsigned col_pos, line_pos, off_x, off_y, cur_col;
  int errs = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned stride(int unsigned size, int unsigned div);
    int unsigned s;
    s = size / ((div == 0) ? 1 : div);
    return (s == 0) ? 1 : s;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < LineMax; i++) begin
      sum_r[i] = 0;
      sum_g[i] = 0;
      sum_b[i] = 0;
    end
    col_pos = 0;
    line_pos = 0;
    off_x = 0;
    off_y = 0;
    cur_col = 0;
  endfunction

  // Accumulate one pixel; queue a block mean when its bottom-right pixel lands.
  function automatic void accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, sx, sy, bc, cnt;
    bit end_line, end_frame, end_x, end_y;
    block_mean_t m;
    w  = clamp_dim(width_reg, LineMax);
    h  = clamp_dim(height_reg, FrameMax);
    sx = stride(w, divx_reg);
    sy = stride(h, divy_reg);
    bc = (cur_col >= LineMax) ? LineMax - 1 : cur_col;
    sum_r[bc] += r;
    sum_g[bc] += g;
    sum_b[bc] += b;
    end_line  = (col_pos + 1 >= w);
    end_frame = end_line && (line_pos + 1 >= h);
    end_x     = (off_x + 1 >= sx) || end_line;
    end_y     = (off_y + 1 >= sy) || (line_pos + 1 >= h);
    if (end_x && end_y) begin
      cnt    = (off_x + 1) * (off_y + 1);
      m.col  = bc[CoordW-1:0];
      m.row  = CoordW'(line_pos / sy);
      m.r    = 8'(sum_r[bc] / cnt);
      m.g    = 8'(sum_g[bc] / cnt);
      m.b    = 8'(sum_b[bc] / cnt);
      m.done = end_frame;
      block_q = {block_q, m};
      sum_r[bc] = 0;
      sum_g[bc] = 0;
      sum_b[bc] = 0;
    end
    if (end_line) begin
      col_pos = 0;
      off_x = 0;
      cur_col = 0;
      if (end_frame) begin
        line_pos = 0;
        off_y = 0;
      end else begin
        line_pos = line_pos + 1;
        off_y = (off_y + 1 >= sy) ? 0 : off_y + 1;
      end
    end else begin
      col_pos = col_pos + 1;
      if (off_x + 1 >= sx) begin
        off_x = 0;
        cur_col = bc + 1;
      end else begin
        off_x = off_x + 1;
        cur_col = bc;
      end
    end
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    block_mean_t m;
    if (!rst_n) begin
      width_reg  = CfgW'(640);
      height_reg = CfgW'(480);
      divx_reg   = CfgW'(8);
      divy_reg   = CfgW'(8);
      restart_frame();
      block_q.delete();
    end else begin
      if (pop && !empty) begin
        if (block_q.size() == 0) begin
          $display("%0t: unexpected word, col %0d row %0d", $time,
                   out_block_column, out_block_row);
          errs++;
        end else begin
          m = block_q.pop_front();
          cmp_field("block_column", m.col, out_block_column);
          cmp_field("block_row", m.row, out_block_row);
          cmp_field("mean_red", m.r, out_mean_red);
          cmp_field("mean_green", m.g, out_mean_green);
          cmp_field("mean_blue", m.b, out_mean_blue);
          cmp_field("frame_done", m.done, out_frame_done);
        end
      end
      if (cfg_we) begin
        if (cfg_index[2] == 1'b0) begin
          case (cfg_index[1:0])
            RegWidth:  width_reg  = cfg_data;
            RegHeight: height_reg = cfg_data;
            RegDivX:   divx_reg   = cfg_data;
            RegDivY:   divy_reg   = cfg_data;
            default: ;
          endcase
          restart_frame();
        end
      end
      if (push && !full)
        accumulate_pixel(in_pixel_red, in_pixel_green, in_pixel_blue);
    end
    mismatches <= errs;
    blocks_pending <= block_q.size();
  end
endmodule

// ===== tb/sv/block_average_mosaic_test.sv =====
// Top of the block average mosaic testbench: stimulus, receiver stalls and verdict.
module block_average_mosaic_test;
  import bam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  // Front end plus divider latency, with margin.
  localparam int Settle = 64;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic push, full, empty, pop;
  logic [7:0] in_pixel_red, in_pixel_green, in_pixel_blue;
  logic [CoordW-1:0] out_block_column, out_block_row;
  logic [7:0] out_mean_red, out_mean_green, out_mean_blue;
  logic out_frame_done;

  int mismatches, blocks_pending;
  int pixels_sent;
  int cycles = 0;
  bit long_hold;   // asks the receiver for one long hold-off
  bit hold_done;

  block_average_mosaic dut (.*);
  block_average_mosaic_check chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: randomly chosen stall patterns, plus one long hold-off on request.
  initial begin
    int mode;
    pop <= 1'b0;
    hold_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(2, 0);
      repeat ($urandom_range(200, 20)) begin
        if (long_hold && !hold_done) begin
          pop <= 1'b0;
          repeat (500) @(posedge clk);
          hold_done = 1;
        end
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(1, 0));
          default: pop <= ($urandom_range(7, 0) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // All tasks below start and end right after a rising edge.
  task automatic drain();
    while (blocks_pending != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic set_grid(int w, int h, int dx, int dy);
    int order[4] = '{0, 1, 2, 3};
    int vals[4];
    vals = '{w, h, dx, dy};
    order.shuffle();
    foreach (order[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(order[i]);
      cfg_data  <= CfgW'(vals[order[i]]);
      @(posedge clk);
    end
    // Occasionally poke an unused index; it must not restart anything.
    if ($urandom_range(3, 0) == 0) begin
      cfg_index <= 3'($urandom_range(7, 4));
      cfg_data  <= CfgW'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Push one word and hold until it is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    push           <= 1'b1;
    in_pixel_red   <= r;
    in_pixel_green <= g;
    in_pixel_blue  <= b;
    do @(posedge clk); while (full);
    pixels_sent++;
  endtask

  // Random pixels in bursts with random gaps; some stretches run gap-free.
  task automatic send_random(int n);
    int burst, gap_max;
    gap_max = $urandom_range(1, 0) ? 0 : $urandom_range(6, 1);
    while (n > 0) begin
      burst = $urandom_range(20, 1);
      while (burst > 0 && n > 0) begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        burst--;
        n--;
      end
      if (gap_max != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(posedge clk);
      end
    end
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int w, int h, int dx, int dy, int n);
    drain();
    set_grid(w, h, dx, dy);
    send_random(n);
  endtask

  initial begin
    int w, h, dx, dy, n, pick;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    push           <= 1'b0;
    in_pixel_red   <= '0;
    in_pixel_green <= '0;
    in_pixel_blue  <= '0;
    long_hold      = 0;
    pixels_sent    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset grid (640x480, 8x8): a few extreme pixels, no block finishes.
    send_pixel(8'h00, 8'hFF, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    push <= 1'b0;
    @(posedge clk);

    // 5x3 with 2x2 divisions: short edge column, frame wrap into a new frame.
    drain();
    set_grid(5, 3, 2, 2);
    for (int i = 0; i < 16; i++)
      send_pixel((i % 2) ? 8'hFF : 8'h00, 8'h55 ^ {8{i[0]}}, 8'(i * 17));
    push <= 1'b0;
    @(posedge clk);

    // Zero sizes and zero divisions: a 1x1 frame, a block per pixel.
    drain();
    set_grid(0, 0, 0, 0);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'h01, 8'hFE, 8'h7F);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    push <= 1'b0;
    @(posedge clk);

    // Unit strides and a long receiver hold-off: the block backs up and stalls.
    // The hold starts once the memory clear and stride computation are over, so pixels really flow.
    drain();
    set_grid(8, 8, 8, 8);
    while (full) @(posedge clk);
    long_hold = 1;
    send_random(150);
    long_hold = 0;

    // Oversized width with huge divisions: clamped width, stride clamped to one.
    run_phase(4095, 1, 4095, 4095, 120);
    // Oversized height, one column: a block per line.
    run_phase(1, 4095, 2048, 4095, 120);
    // More divisions than pixels, all bits of the data word set.
    run_phase(3, 2, 4095, 4095, 30);

    while (pixels_sent < 1500) begin
      pick = $urandom_range(9, 0);
      w  = $urandom_range(24, 1);
      h  = $urandom_range(12, 1);
      dx = $urandom_range(w + 2, 0);
      dy = $urandom_range(h + 2, 0);
      if (pick == 0) w = 0;
      if (pick == 1) dx = 1;
      n = w * h * $urandom_range(3, 1) + $urandom_range(5, 0);
      if (n > 200) n = 200;
      run_phase(w, h, dx, dy, n);
    end

    drain();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
